FILE: src/fbgd_pkg.sv
// Shared types, constants and codes for the FAT parameter block geometry decoder.
// No dependencies; used by every module under src.
`default_nettype none

package fbgd_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_BAD_GEOM  = 2'd2;
	localparam logic [1:0] ST_FAT_SMALL = 2'd3;

	// File system type codes
	localparam logic [1:0] FS_FAT12 = 2'd0;
	localparam logic [1:0] FS_FAT16 = 2'd1;
	localparam logic [1:0] FS_FAT32 = 2'd2;

	// Cluster count thresholds
	localparam logic [31:0] FAT12_LIMIT = 32'd4085;
	localparam logic [31:0] FAT16_LIMIT = 32'd65525;

	// A directory entry is 32 bytes: shift by five
	localparam int DIR_ENTRY_SHIFT = 5;

	// Width of the root directory sector count and its dividend
	localparam int ROOT_W = 22;

	localparam logic [15:0] MAX_SECTOR_RESET = 16'd512;

	// Quotient bits resolved per divider stage
	localparam int DIV_STEP_DEFAULT = 2;

	typedef struct packed {
		logic [15:0] bytes_per_sector;
		logic [7:0]  sectors_per_cluster;
		logic [15:0] reserved_sectors;
		logic [7:0]  fat_copies;
		logic [15:0] root_entry_count;
		logic [15:0] fat_sectors_short;
		logic [31:0] fat_sectors_long;
		logic [15:0] total_sectors_short;
		logic [31:0] total_sectors_long;
		logic [31:0] part_start_lba;
	} in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  fs_type;
		logic [21:0] root_dir_sectors;
		logic [31:0] fat_size;
		logic [31:0] vol_sectors;
		logic [31:0] data_sectors;
		logic [31:0] cluster_count;
		logic [31:0] first_data_sector;
		logic [31:0] fat_start_sector;
	} out_t;

	// Side data carried along the divider
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] bps;
		logic [2:0]  sh;
		logic [15:0] rsvd;
		logic [31:0] fat;
		logic [31:0] total;
		logic [39:0] cf;
		logic [31:0] fat_start;
	} carry_t;

endpackage

`default_nettype wire

FILE: src/fbgd_front.sv
// Front stage: size checks, field selection, FAT copies product and root dividend.
// Depends on fbgd_pkg.
`default_nettype none

module fbgd_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [15:0]                max_sector_bytes,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire fbgd_pkg::in_t              in_data,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output fbgd_pkg::carry_t                out_carry,
	output logic [fbgd_pkg::ROOT_W-1:0]     out_num
);

	logic                          v_s1;
	logic                          ld;
	fbgd_pkg::carry_t              c_nxt;
	fbgd_pkg::carry_t              c_s1;
	logic [fbgd_pkg::ROOT_W-1:0]   num_nxt;
	logic [fbgd_pkg::ROOT_W-1:0]   num_s1;
	logic [7:0]                    spc;
	logic                          bad;

	assign ld       = !v_s1 || !out_stall;
	assign in_stall = !ld;
	assign spc      = in_data.sectors_per_cluster;
	assign bad      = (in_data.bytes_per_sector == 16'd0) || (spc == 8'd0)
		|| ((spc & (spc - 8'd1)) != 8'd0);

	// Decode checks, pick short or long fields, form ceil dividend
	always_comb begin
		c_nxt.sh = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (spc[i]) begin
				c_nxt.sh = 3'(i);
			end
		end
		if (in_data.bytes_per_sector > max_sector_bytes) begin
			c_nxt.status = fbgd_pkg::ST_TOO_LARGE;
		end else if (bad) begin
			c_nxt.status = fbgd_pkg::ST_BAD_GEOM;
		end else begin
			c_nxt.status = fbgd_pkg::ST_OK;
		end
		c_nxt.bps  = in_data.bytes_per_sector;
		c_nxt.rsvd = in_data.reserved_sectors;
		c_nxt.fat  = (in_data.fat_sectors_short != 16'd0) ?
			32'(in_data.fat_sectors_short) : in_data.fat_sectors_long;
		c_nxt.total = (in_data.total_sectors_short != 16'd0) ?
			32'(in_data.total_sectors_short) : in_data.total_sectors_long;
		c_nxt.cf = 40'(in_data.fat_copies) * 40'(c_nxt.fat);
		c_nxt.fat_start = 32'(in_data.reserved_sectors) + in_data.part_start_lba;
		num_nxt = (fbgd_pkg::ROOT_W'(in_data.root_entry_count) << fbgd_pkg::DIR_ENTRY_SHIFT)
			+ fbgd_pkg::ROOT_W'(in_data.bytes_per_sector) - fbgd_pkg::ROOT_W'(1);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld) begin
			v_s1 <= in_valid;
		end
	end

	// Hold payload under stall
	always_ff @(posedge clk) begin
		if (ld) begin
			c_s1   <= c_nxt;
			num_s1 <= num_nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_carry = c_s1;
	assign out_num   = num_s1;

endmodule

`default_nettype wire

FILE: src/fbgd_div.sv
// Pipelined restoring divider for root directory sectors, STEP quotient bits per stage.
// Depends on fbgd_pkg; carries the side data alongside each request.
`default_nettype none

module fbgd_div #(
	parameter int STEP = fbgd_pkg::DIV_STEP_DEFAULT
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire fbgd_pkg::carry_t         in_carry,
	input  wire logic [fbgd_pkg::ROOT_W-1:0] in_num,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output fbgd_pkg::carry_t              out_carry,
	output logic [fbgd_pkg::ROOT_W-1:0]   out_quot
);

	localparam int STAGES = (fbgd_pkg::ROOT_W + STEP - 1) / STEP;
	localparam int W      = STAGES * STEP;

	logic               v_s   [STAGES];
	logic [15:0]        rem_s [STAGES];
	logic [W-1:0]       n_s   [STAGES];
	logic [W-1:0]       q_s   [STAGES];
	fbgd_pkg::carry_t   c_s   [STAGES];
	logic [STAGES-1:0]  ld;

	// Stage load enables ripple back from the output
	always_comb begin
		ld[STAGES-1] = !v_s[STAGES-1] || !out_stall;
		for (int k = STAGES - 2; k >= 0; k--) begin
			ld[k] = !v_s[k] || ld[k+1];
		end
	end

	assign in_stall = !ld[0];

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic [15:0]      rem_p;
		logic [W-1:0]     n_p;
		logic [W-1:0]     q_p;
		fbgd_pkg::carry_t c_p;
		logic             v_p;
		logic [15:0]      rem_n;
		logic [W-1:0]     n_n;
		logic [W-1:0]     q_n;

		if (k == 0) begin : g_first
			assign rem_p = 16'd0;
			assign n_p   = W'(in_num);
			assign q_p   = '0;
			assign c_p   = in_carry;
			assign v_p   = in_valid;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign n_p   = n_s[k-1];
			assign q_p   = q_s[k-1];
			assign c_p   = c_s[k-1];
			assign v_p   = v_s[k-1];
		end

		// Shift in a dividend bit, subtract divisor when it fits
		always_comb begin
			logic [16:0] t;
			logic        ge;
			rem_n = rem_p;
			n_n   = n_p;
			q_n   = q_p;
			for (int j = 0; j < STEP; j++) begin
				t  = {rem_n, n_n[W-1]};
				ge = t >= {1'b0, c_p.bps};
				if (ge) begin
					t = t - {1'b0, c_p.bps};
				end
				rem_n = t[15:0];
				q_n   = {q_n[W-2:0], ge};
				n_n   = {n_n[W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (ld[k]) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				rem_s[k] <= rem_n;
				n_s[k]   <= n_n;
				q_s[k]   <= q_n;
				c_s[k]   <= c_p;
			end
		end
	end

	assign out_valid = v_s[STAGES-1];
	assign out_carry = c_s[STAGES-1];
	assign out_quot  = q_s[STAGES-1][fbgd_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

FILE: src/fbgd_back.sv
// Back end: overhead, data sectors, clusters, type, FAT size check and result register.
// Depends on fbgd_pkg; fed by the divider.
`default_nettype none

module fbgd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire fbgd_pkg::carry_t            in_carry,
	input  wire logic [fbgd_pkg::ROOT_W-1:0] in_root,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output fbgd_pkg::out_t                   out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic ld1, ld2, ld3, ld4;

	// Stage 1 registers
	logic [1:0]  st_s1;
	logic [15:0] bps_s1;
	logic [2:0]  sh_s1;
	logic [31:0] fat_s1, total_s1, fds_s1, fst_s1;
	logic [40:0] ovh_s1;
	logic [21:0] root_s1;

	// Stage 2 registers
	logic [1:0]  st_s2;
	logic [15:0] bps_s2;
	logic [31:0] fat_s2, total_s2, fds_s2, fst_s2, data_s2, clus_s2;
	logic [21:0] root_s2;

	// Stage 3 registers
	logic [1:0]  st_s3, ty_s3;
	logic [31:0] fat_s3, total_s3, fds_s3, fst_s3, data_s3, clus_s3;
	logic [21:0] root_s3;
	logic [33:0] need_s3;
	logic [47:0] prod_s3;

	fbgd_pkg::out_t res_s4;

	// Combinational values per stage
	logic [40:0] ovh_n;
	logic [31:0] fds_n;
	logic        under;
	logic [31:0] data_n;
	logic [1:0]  ty_n;
	logic [33:0] need_n;
	logic        fat_short;
	fbgd_pkg::out_t res_n;

	assign ld4      = !v_s4 || !out_stall;
	assign ld3      = !v_s3 || ld4;
	assign ld2      = !v_s2 || ld3;
	assign ld1      = !v_s1 || ld2;
	assign in_stall = !ld1;

	// Overhead exactly, first data sector modulo 2^32
	assign ovh_n = 41'(in_carry.rsvd) + 41'(in_carry.cf) + 41'(in_root);
	assign fds_n = in_carry.fat_start + in_carry.cf[31:0] + 32'(in_root);

	// Data region and underflow
	assign under  = {9'd0, total_s1} < ovh_s1;
	assign data_n = total_s1 - ovh_s1[31:0];

	// Classify by cluster count and form needed FAT bytes
	always_comb begin
		if (clus_s2 < fbgd_pkg::FAT12_LIMIT) begin
			ty_n   = fbgd_pkg::FS_FAT12;
			need_n = {2'b00, clus_s2} + {3'b000, clus_s2[31:1]};
		end else if (clus_s2 < fbgd_pkg::FAT16_LIMIT) begin
			ty_n   = fbgd_pkg::FS_FAT16;
			need_n = {1'b0, clus_s2, 1'b0};
		end else begin
			ty_n   = fbgd_pkg::FS_FAT32;
			need_n = {clus_s2, 2'b00};
		end
	end

	// FAT too small when its bytes fall short of the needed bytes
	assign fat_short = {14'd0, need_s3} > prod_s3;

	always_comb begin
		res_n = '0;
		if (st_s3 != fbgd_pkg::ST_OK) begin
			res_n.status = st_s3;
		end else begin
			res_n.status            = fat_short ? fbgd_pkg::ST_FAT_SMALL : fbgd_pkg::ST_OK;
			res_n.fs_type           = ty_s3;
			res_n.root_dir_sectors  = root_s3;
			res_n.fat_size          = fat_s3;
			res_n.vol_sectors       = total_s3;
			res_n.data_sectors      = data_s3;
			res_n.cluster_count     = clus_s3;
			res_n.first_data_sector = fds_s3;
			res_n.fat_start_sector  = fst_s3;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld1) begin
				v_s1 <= in_valid;
			end
			if (ld2) begin
				v_s2 <= v_s1;
			end
			if (ld3) begin
				v_s3 <= v_s2;
			end
			if (ld4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Hold payload under stall
	always_ff @(posedge clk) begin
		if (ld1) begin
			st_s1    <= in_carry.status;
			bps_s1   <= in_carry.bps;
			sh_s1    <= in_carry.sh;
			fat_s1   <= in_carry.fat;
			total_s1 <= in_carry.total;
			fds_s1   <= fds_n;
			fst_s1   <= in_carry.fat_start;
			ovh_s1   <= ovh_n;
			root_s1  <= in_root;
		end
		if (ld2) begin
			st_s2    <= (st_s1 != fbgd_pkg::ST_OK) ? st_s1 :
				(under ? fbgd_pkg::ST_BAD_GEOM : fbgd_pkg::ST_OK);
			bps_s2   <= bps_s1;
			fat_s2   <= fat_s1;
			total_s2 <= total_s1;
			fds_s2   <= fds_s1;
			fst_s2   <= fst_s1;
			data_s2  <= data_n;
			clus_s2  <= data_n >> sh_s1;
			root_s2  <= root_s1;
		end
		if (ld3) begin
			st_s3    <= st_s2;
			ty_s3    <= ty_n;
			fat_s3   <= fat_s2;
			total_s3 <= total_s2;
			fds_s3   <= fds_s2;
			fst_s3   <= fst_s2;
			data_s3  <= data_s2;
			clus_s3  <= clus_s2;
			root_s3  <= root_s2;
			need_s3  <= need_n;
			prod_s3  <= 48'(fat_s2) * 48'(bps_s2);
		end
		if (ld4) begin
			res_s4 <= res_n;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = res_s4;

endmodule

`default_nettype wire

FILE: src/fat_bpb_geometry_decode_unit.sv
// Top level of the FAT parameter block geometry decoder: config register and pipeline.
// Depends on fbgd_pkg, fbgd_front, fbgd_div and fbgd_back.
//
//   channel | handshake        | payload
//   --------+------------------+---------------------------
//   in      | in_valid/stall   | in_data  (fbgd_pkg::in_t)
//   out     | out_valid/stall  | out_data (fbgd_pkg::out_t)
//   cfg     | cfg_valid/ready  | cfg_data (max sector bytes)
//
// One request enters per cycle while in_stall is low. The restoring divider for root
// directory sectors has 11 stages at default. Reset clears all valid bits and sets the
// max sector size to 512. A stall on the output holds the last stage; bubbles ahead of
// it still fill in. The config register is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce.
`default_nettype none

module fat_bpb_geometry_decode_unit #(
	parameter int DIV_STEP = fbgd_pkg::DIV_STEP_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire fbgd_pkg::in_t   in_data,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output fbgd_pkg::out_t       out_data,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [15:0]     cfg_data
);

	logic [15:0]                 max_sector_bytes_q;
	logic                        f_valid, f_stall;
	fbgd_pkg::carry_t            f_carry;
	logic [fbgd_pkg::ROOT_W-1:0] f_num;
	logic                        d_valid, d_stall;
	fbgd_pkg::carry_t            d_carry;
	logic [fbgd_pkg::ROOT_W-1:0] d_quot;

	assign cfg_ready = 1'b1;

	// Hold the max sector size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_sector_bytes_q <= fbgd_pkg::MAX_SECTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_sector_bytes_q <= cfg_data;
		end
	end

	fbgd_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.max_sector_bytes (max_sector_bytes_q),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_data          (in_data),
		.out_valid        (f_valid),
		.out_stall        (f_stall),
		.out_carry        (f_carry),
		.out_num          (f_num)
	);

	fbgd_div #(
		.STEP (DIV_STEP)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_stall  (f_stall),
		.in_carry  (f_carry),
		.in_num    (f_num),
		.out_valid (d_valid),
		.out_stall (d_stall),
		.out_carry (d_carry),
		.out_quot  (d_quot)
	);

	fbgd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_stall  (d_stall),
		.in_carry  (d_carry),
		.in_root   (d_quot),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// Too-large and bad-geometry results carry no geometry
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == fbgd_pkg::ST_TOO_LARGE
			|| out_data.status == fbgd_pkg::ST_BAD_GEOM)
		|-> out_data.fs_type == 2'd0 && out_data.fat_size == 32'd0
			&& out_data.cluster_count == 32'd0 && out_data.first_data_sector == 32'd0)
		else $error("error result carries geometry");

	// FAT12 type agrees with cluster count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.fs_type == fbgd_pkg::FS_FAT12
			&& (out_data.status == fbgd_pkg::ST_OK
				|| out_data.status == fbgd_pkg::ST_FAT_SMALL)
		|-> out_data.cluster_count < fbgd_pkg::FAT12_LIMIT)
		else $error("FAT12 with too many clusters");

	// Clusters never exceed data sectors
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.cluster_count <= out_data.data_sectors)
		else $error("cluster count above data sectors");

endmodule

`default_nettype wire
